/* src/lfdw_pkg.sv */
// Shared types, constants and lookup functions for the LED fade dimmer.
package lfdw_pkg;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_SET  = 2'd1,
      KIND_WAKE = 2'd2
   } kind_type;

   localparam int unsigned CSR_FADE_STEP = 0;
   localparam int unsigned CSR_WAKE_STEP = 1;

   localparam logic [15:0] FADE_STEP_RESET = 16'd10;
   localparam logic [28:0] WAKE_STEP_RESET = 29'd60000;

   localparam logic [6:0] LEVEL_MAX   = 7'd100;
   localparam logic [3:0] LADDER_LAST = 4'd9;
   localparam logic [7:0] WAKE_DUTY   = 8'd1;

   // floor(level * 255 / 100) as level * 1336965 / 2^19, exact for level 0..100
   localparam logic [20:0] DUTY_RECIP = 21'd1336965;
   localparam int unsigned DUTY_SHIFT = 19;

   function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
      logic [27:0] prod;
      prod = 28'(pct) * 28'(DUTY_RECIP);
      return prod[DUTY_SHIFT +: 8];
   endfunction

   function automatic logic [7:0] ladder_duty(input logic [3:0] step);
      logic [7:0] d;
      case (step)
         4'd1:    d = 8'd2;
         4'd2:    d = 8'd3;
         4'd3:    d = 8'd5;
         4'd4:    d = 8'd10;
         4'd5:    d = 8'd15;
         4'd6:    d = 8'd20;
         4'd7:    d = 8'd30;
         4'd8:    d = 8'd40;
         4'd9:    d = 8'd50;
         default: d = 8'd0;
      endcase
      return d;
   endfunction

endpackage

/* src/led_fade_dimmer_wakeup.sv */
// LED dimmer with soft fade and wake-up ladder: input register, update logic, result register.
//
// Each transfer on req_ is one item: an update tick, a set on/off command or a wake-up start,
// with the current millisecond time. Every item yields exactly one transfer on rsp_ with the
// duty issued (if any), the fade level, the ramp flag and the active ladder step. The block
// takes one item per clock while rsp_ is ready: an item waits in the input register, its
// state update and result land in the state and result registers together, and rsp_
// back-pressure only stalls req_ once both registers hold data. Fade and ladder periods
// must be written on csr_ only while no item is in flight; the block does not enforce this.
module led_fade_dimmer_wakeup
   import lfdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms[31:0], button_changed[32], set_on[33], zero fill
   input  logic [1:0]  req_tuser,   // kind[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // duty[7:0], level_pct[14:8], fade_busy[15],
                                    // ladder_step[19:16], zero fill
   output logic [0:0]  rsp_tuser,   // duty_write[0]

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [28:0] csr_data
);

   // configuration
   logic [15:0] fade_step_ff;
   logic [28:0] wake_step_ff;

   // input register
   logic        in_valid_ff;
   kind_type    in_kind_ff;
   logic [31:0] in_now_ff;
   logic        in_button_ff;
   logic        in_set_on_ff;

   // dimmer state
   logic [6:0]  level_ff,      level_in;
   logic        ramping_ff,    ramping_in;
   logic        toward_on_ff,  toward_on_in;
   logic [31:0] last_step_ff,  last_step_in;
   logic [31:0] ladder_t0_ff,  ladder_t0_in;
   logic [3:0]  ladder_idx_ff, ladder_idx_in;

   // result register
   logic        out_valid_ff;
   logic        out_write_ff,  out_write_in;
   logic [7:0]  out_duty_ff,   out_duty_in;

   logic        advance;
   logic [31:0] fade_elapsed;
   logic [31:0] wake_elapsed;
   logic [32:0] wake_due_at;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign fade_elapsed = in_now_ff - last_step_ff;
   assign wake_elapsed = in_now_ff - ladder_t0_ff;

   always_comb begin
      logic       skip_ladder;
      logic [3:0] idx;
      skip_ladder   = 1'b0;
      level_in      = level_ff;
      ramping_in    = ramping_ff;
      toward_on_in  = toward_on_ff;
      last_step_in  = last_step_ff;
      ladder_t0_in  = ladder_t0_ff;
      ladder_idx_in = ladder_idx_ff;
      out_write_in  = 1'b0;
      out_duty_in   = 8'd0;
      wake_due_at   = 33'd0;
      idx           = 4'd0;

      case (in_kind_ff)
         KIND_TICK: begin
            if (in_button_ff && !ramping_ff) begin
               ramping_in    = 1'b1;
               toward_on_in  = !toward_on_ff;
               ladder_idx_in = 4'd0;
            end
            if (ramping_in && fade_elapsed >= 32'(fade_step_ff)) begin
               last_step_in = in_now_ff;
               if (toward_on_in) begin
                  if (level_ff >= LEVEL_MAX) begin
                     level_in    = LEVEL_MAX;
                     ramping_in  = 1'b0;
                     skip_ladder = 1'b1;
                  end else begin
                     level_in = level_ff + 7'd1;
                  end
               end else begin
                  if (level_ff == 7'd0) begin
                     ramping_in  = 1'b0;
                     skip_ladder = 1'b1;
                  end else begin
                     level_in = level_ff - 7'd1;
                  end
               end
               if (!skip_ladder) begin
                  out_write_in = 1'b1;
                  out_duty_in  = pct_to_duty(level_in);
               end
            end
            idx         = ladder_idx_in;
            wake_due_at = 33'(wake_step_ff) * 33'(idx);
            if (!skip_ladder && (idx inside {[4'd1:LADDER_LAST]})
                && 33'(wake_elapsed) >= wake_due_at) begin
               out_write_in  = 1'b1;
               out_duty_in   = ladder_duty(idx);
               ladder_idx_in = (idx == LADDER_LAST) ? 4'd0 : idx + 4'd1;
            end
         end
         KIND_SET: begin
            ramping_in    = 1'b1;
            toward_on_in  = in_set_on_ff;
            ladder_idx_in = 4'd0;
         end
         KIND_WAKE: begin
            // restart the ladder unless it sits on its first step
            if (ladder_idx_ff != 4'd1) begin
               toward_on_in  = 1'b1;
               ladder_t0_in  = in_now_ff;
               ladder_idx_in = 4'd1;
               out_write_in  = 1'b1;
               out_duty_in   = WAKE_DUTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_step_ff  <= FADE_STEP_RESET;
         wake_step_ff  <= WAKE_STEP_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         level_ff      <= 7'd0;
         ramping_ff    <= 1'b0;
         toward_on_ff  <= 1'b0;
         last_step_ff  <= 32'd0;
         ladder_t0_ff  <= 32'd0;
         ladder_idx_ff <= 4'd0;
      end else begin
         if (csr_valid) begin
            if (csr_index == 1'(CSR_FADE_STEP)) begin
               fade_step_ff <= csr_data[15:0];
            end else begin
               wake_step_ff <= csr_data;
            end
         end

         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff  <= 1'b1;
            level_ff      <= level_in;
            ramping_ff    <= ramping_in;
            toward_on_ff  <= toward_on_in;
            last_step_ff  <= last_step_in;
            ladder_t0_ff  <= ladder_t0_in;
            ladder_idx_ff <= ladder_idx_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff   <= kind_type'(req_tuser);
         in_now_ff    <= req_tdata[31:0];
         in_button_ff <= req_tdata[32];
         in_set_on_ff <= req_tdata[33];
      end
      if (advance) begin
         out_write_ff <= out_write_in;
         out_duty_ff  <= out_duty_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_write_ff;
   assign rsp_tdata  = {4'd0, ladder_idx_ff, ramping_ff, level_ff, out_duty_ff};

endmodule

/* test/tb_top.sv */
// Testbench for the LED fade dimmer: directed and random items checked against a local predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lfdw_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 120;
   localparam int PHASES         = 7;
   localparam kind_type KIND_UNUSED = kind_type'(2'd3);

   typedef struct packed {
      kind_type    kind;
      logic [31:0] now;
      logic        button;
      logic        set_on;
   } dim_item_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] duty;
      logic [6:0] level;
      logic       busy;
      logic [3:0] step;
   } dim_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [28:0] csr_data = '0;

   led_fade_dimmer_wakeup uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state and its copy of the registers
   logic [15:0] fade_period = FADE_STEP_RESET;
   logic [28:0] wake_period = WAKE_STEP_RESET;
   logic [6:0]  level_q     = '0;
   logic        ramp_on     = 1'b0;
   logic        dir_up      = 1'b0;
   logic [31:0] last_fade_ms = '0;
   logic [31:0] ladder_t0   = '0;
   logic [3:0]  step_idx    = '0;
   logic [7:0]  wake_levels [10] = '{8'd0, 8'd2, 8'd3, 8'd5, 8'd10, 8'd15, 8'd20, 8'd30,
                                     8'd40, 8'd50};

   dim_item_type   pending_items[$];
   dim_result_type expected_results[$];
   int          items_sent   = 0;
   int          results_seen = 0;
   int          errors       = 0;
   int          idle_cycles  = 0;
   bit          req_fire     = 1'b0;
   bit          rsp_fire     = 1'b0;
   logic [31:0] gen_now      = '0;

   function automatic dim_result_type dimmer_predict(input dim_item_type it);
      dim_result_type r;
      logic [31:0] since;
      logic        skip_ladder;
      r = '0;
      skip_ladder = 1'b0;
      case (it.kind)
         KIND_TICK: begin
            if (it.button && !ramp_on) begin
               ramp_on = 1'b1;
               dir_up = !dir_up;
               step_idx = '0;
            end
            since = it.now - last_fade_ms;
            if (ramp_on && since >= 32'(fade_period)) begin
               last_fade_ms = it.now;
               if (dir_up && level_q >= LEVEL_MAX) begin
                  level_q = LEVEL_MAX;
                  ramp_on = 1'b0;
                  skip_ladder = 1'b1;
               end else if (!dir_up && level_q == 7'd0) begin
                  ramp_on = 1'b0;
                  skip_ladder = 1'b1;
               end else begin
                  level_q = dir_up ? level_q + 7'd1 : level_q - 7'd1;
                  r.duty = 8'((16'(level_q) * 16'd255) / 16'd100);
                  r.wr = 1'b1;
               end
            end
            if (!skip_ladder && step_idx >= 4'd1 && step_idx <= LADDER_LAST) begin
               since = it.now - ladder_t0;
               // product taken at full width, no wrap
               if (64'(since) >= 64'(wake_period) * 64'(step_idx)) begin
                  r.duty = wake_levels[step_idx];
                  r.wr = 1'b1;
                  step_idx = (step_idx == LADDER_LAST) ? 4'd0 : step_idx + 4'd1;
               end
            end
         end
         KIND_SET: begin
            ramp_on = 1'b1;
            dir_up = it.set_on;
            step_idx = '0;
         end
         KIND_WAKE: begin
            if (step_idx != 4'd1) begin
               dir_up = 1'b1;
               ladder_t0 = it.now;
               step_idx = 4'd1;
               r.duty = WAKE_DUTY;
               r.wr = 1'b1;
            end
         end
         default: ;
      endcase
      r.level = level_q;
      r.busy = ramp_on;
      r.step = step_idx;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Sender: hold an item until its transfer, then wait the drawn gap
   int req_gap = 0;
   bit req_idle_on = 1'b1;
   always @(negedge clock) begin
      dim_item_type it;
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset && !(req_tvalid && !req_fire)) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_tdata <= {6'd0, it.set_on, it.button, it.now};
            req_tuser <= it.kind;
            next_valid = 1'b1;
            if ($urandom_range(0, 39) == 0) req_idle_on = !req_idle_on;
            req_gap = req_idle_on ? $urandom_range(0, 17) : 0;
         end
      end
      req_tvalid <= next_valid;
   end

   // Receiver: random stalls per result, plus a long hold-off now and then
   int rsp_stall = 0;
   int hold_left = 0;
   int hold_mark = 150;
   bit rsp_idle_on = 1'b0;
   always @(negedge clock) begin
      if (rsp_fire) begin
         if ($urandom_range(0, 39) == 0) rsp_idle_on = !rsp_idle_on;
         rsp_stall = rsp_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (results_seen >= hold_mark) begin
         hold_left = HOLD_CYCLES;
         hold_mark += 350;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      dim_item_type it;
      dim_result_type want;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire) begin
         it.kind = kind_type'(req_tuser);
         it.now = req_tdata[31:0];
         it.button = req_tdata[32];
         it.set_on = req_tdata[33];
         expected_results.push_back(dimmer_predict(it));
      end
      if (rsp_fire) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual tuser %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            check_field("duty_write", 32'(want.wr), 32'(rsp_tuser[0]));
            check_field("duty", 32'(want.duty), 32'(rsp_tdata[7:0]));
            check_field("level_pct", 32'(want.level), 32'(rsp_tdata[14:8]));
            check_field("fade_busy", 32'(want.busy), 32'(rsp_tdata[15]));
            check_field("ladder_step", 32'(want.step), 32'(rsp_tdata[19:16]));
         end
      end
      if (!reset) begin
         if (req_fire || rsp_fire || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic queue_item(input kind_type kind, input logic [31:0] now, input logic button,
                             input logic set_on);
      dim_item_type it;
      it.kind = kind;
      it.now = now;
      it.button = button;
      it.set_on = set_on;
      pending_items.push_back(it);
      items_sent++;
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [28:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == 1'(CSR_FADE_STEP)) fade_period = val[15:0];
      else wake_period = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_seen < items_sent);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic advance_fade();
      gen_now += $urandom_range(0, 32'(fade_period) * 2 + 1);
   endtask

   task automatic advance_wake();
      gen_now += 32'(wake_period) / 2 + $urandom_range(0, 32'(wake_period)) + $urandom_range(0, 3);
   endtask

   // One sequence: a ramp, a wake-up ladder run, or loose noise
   task automatic add_burst();
      int n;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         advance_fade();
         queue_item(KIND_SET, gen_now, 1'($urandom), 1'($urandom));
         n = $urandom_range(20, 110);
         repeat (n) begin
            advance_fade();
            queue_item(KIND_TICK, gen_now, $urandom_range(0, 19) == 0, 1'($urandom));
         end
      end else if (pick < 7) begin
         advance_fade();
         queue_item(KIND_WAKE, gen_now, 1'($urandom), 1'($urandom));
         n = $urandom_range(8, 24);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) advance_fade();
            else advance_wake();
            queue_item(KIND_TICK, gen_now, $urandom_range(0, 9) == 0, 1'($urandom));
         end
      end else begin
         n = $urandom_range(5, 20);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) gen_now = $urandom;
            else advance_fade();
            queue_item(kind_type'(2'($urandom_range(0, 2))), gen_now, 1'($urandom),
                       1'($urandom));
         end
      end
   endtask

   initial begin
      logic [15:0] fade_set [PHASES];
      logic [28:0] wake_set [PHASES];
      int start;
      int target;
      fade_set = '{16'd0, 16'd65535, 16'd1, 16'd3, 16'($urandom_range(0, 40)), 16'd10,
                   16'($urandom_range(0, 65535))};
      wake_set = '{29'd0, 29'd400000000, 29'd1, 29'd7, 29'($urandom_range(0, 500)), 29'd60000,
                   29'($urandom_range(0, 400000000))};
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part, at the reset periods
      @(posedge clock);
      queue_item(KIND_TICK, 32'd0, 1'b0, 1'b0);
      queue_item(KIND_UNUSED, 32'd5, 1'b1, 1'b1);
      queue_item(KIND_TICK, 32'd5, 1'b1, 1'b0);         // button while idle: ramp toward on
      queue_item(KIND_TICK, 32'd20, 1'b1, 1'b1);        // button during ramp ignored
      queue_item(KIND_SET, 32'd30, 1'b0, 1'b0);
      queue_item(KIND_TICK, 32'd40, 1'b0, 1'b0);
      queue_item(KIND_TICK, 32'd50, 1'b0, 1'b0);        // clamp at zero, ramp stops
      queue_item(KIND_TICK, 32'd55, 1'b1, 1'b0);
      queue_item(KIND_WAKE, 32'd60, 1'b0, 1'b0);
      queue_item(KIND_WAKE, 32'd61, 1'b0, 1'b1);        // already at step one
      queue_item(KIND_TICK, 32'd60061, 1'b0, 1'b0);     // fade and ladder in one tick
      queue_item(KIND_TICK, 32'd600060, 1'b0, 1'b0);    // only one ladder step per tick
      queue_item(KIND_WAKE, 32'd600070, 1'b0, 1'b0);
      queue_item(KIND_SET, 32'd600080, 1'b0, 1'b1);     // set cancels the ladder
      queue_item(KIND_TICK, 32'hFFFF_FFF0, 1'b0, 1'b0);
      queue_item(KIND_TICK, 32'h0000_0005, 1'b1, 1'b1); // time wrapped
      queue_item(KIND_WAKE, 32'd1000, 1'b0, 1'b0);
      for (int k = 1; k <= 9; k++) queue_item(KIND_TICK, 32'd1000 + 32'd60000 * k, 1'b0, 1'b0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_csr(1'(CSR_FADE_STEP), 29'(fade_set[p]));
         write_csr(1'(CSR_WAKE_STEP), wake_set[p]);
         @(posedge clock);
         start = items_sent;
         // bursts overrun the target by about 30 items on average
         target = (p == 0) ? 260 : 60;
         while (items_sent - start < target) add_burst();
         wait_drained();
      end

      if (expected_results.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, expected_results.size());
      end
      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

/* sim.f */
src/lfdw_pkg.sv
src/led_fade_dimmer_wakeup.sv
test/tb_top.sv
